FILE: hdl/gdbs_pkg.sv
// Shared types, constants and the duty function for the gamepad poll unit.
// No dependencies; imported by gamepad_debounce_backlight_step_unit.
package gdbs_pkg;

  localparam int unsigned ButtonCount = 10;
  localparam int unsigned AxisW       = 12;
  localparam int unsigned LevelW      = 2;
  localparam int unsigned PctW        = 7;
  localparam int unsigned DutyW       = 13;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 12;
  localparam int unsigned InDataW     = 48;
  localparam int unsigned OutDataW    = 32;

  // Button bit positions in the debounced vector
  localparam int unsigned BtnUp    = 0;
  localparam int unsigned BtnRight = 1;
  localparam int unsigned BtnDown  = 2;
  localparam int unsigned BtnLeft  = 3;
  localparam int unsigned BtnPin0  = 4;
  localparam int unsigned BtnStart = 5;

  // Register reset values
  localparam logic [AxisW-1:0]  LowThreshRst  = 12'd1024;
  localparam logic [AxisW-1:0]  HighThreshRst = 12'd3072;
  localparam logic [LevelW-1:0] StartLevelRst = 2'd3;
  localparam logic [LevelW-1:0] LevelRst      = 2'd3;
  localparam logic [PctW-1:0]   PctRst0       = 7'd10;
  localparam logic [PctW-1:0]   PctRst1       = 7'd33;
  localparam logic [PctW-1:0]   PctRst2       = 7'd66;
  localparam logic [PctW-1:0]   PctRst3       = 7'd100;
  localparam logic [PctW-1:0]   PctMax        = 7'd100;

  // Register indexes on the configuration channel
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_THRESH  = 3'd0,
    CFG_HIGH_THRESH = 3'd1,
    CFG_START_LEVEL = 3'd2,
    CFG_PCT_LEVEL0  = 3'd3,
    CFG_PCT_LEVEL1  = 3'd4,
    CFG_PCT_LEVEL2  = 3'd5,
    CFG_PCT_LEVEL3  = 3'd6
  } cfg_idx_e;

  // floor(8191 * pct / 100) = 81*pct + floor(91*pct / 100);
  // the second term uses a reciprocal (5243 / 2^19), exact for 91*pct < 43690.
  function automatic logic [DutyW-1:0] duty_of_pct(input logic [PctW-1:0] pct);
    logic [PctW-1:0] p;
    logic [25:0]     frac;
    logic [DutyW-1:0] base;
    p    = (pct > PctMax) ? PctMax : pct;
    base = DutyW'(p) * 13'd81;
    frac = (26'(p) * 26'd91) * 26'd5243;
    return base + DutyW'(frac >> 19);
  endfunction

endpackage

FILE: hdl/gamepad_debounce_backlight_step_unit.sv
// Gamepad poll unit: axis decode, two-sample button debounce, backlight
// level stepping and dimmer fade requests. Depends on gdbs_pkg.
//
// Each accepted input beat is registered into its result beat.
// Throughput: one beat per cycle; the result register frees up in the same
// cycle it is taken, so input is stalled only while the result waits.
// Duty values are recomputed into a per-level table on percent configuration writes.
// Reset (rst_ni low, async): history all ones, buttons released, level 3,
// nothing pending, default thresholds/percentages, output empty.
module gamepad_debounce_backlight_step_unit import gdbs_pkg::*; #(
  parameter int unsigned LEVEL_COUNT = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: joy_x[11:0], joy_y[23:12], pin_select[24], pin_start[25], pin_a[26],
  //        pin_b[27], pin_menu[28], pin_volume[29], dimmer_ready[30],
  //        dimmer_duty_now[43:31], zero fill [47:44]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: buttons[9:0], backlight_level[11:10], duty_value[24:12],
  //        fade_request[25], save_level[26], zero fill [31:27]
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned LvlIdxW = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam logic [LevelW-1:0] LevelTop = LevelW'(LEVEL_COUNT - 1);

  // Configuration registers
  logic [AxisW-1:0]  low_thr_q, high_thr_q;
  logic [LevelW-1:0] start_lvl_q;
  logic [DutyW-1:0]  duty_tbl_q [LEVEL_COUNT];

  // Tick state
  logic [1:0]             hist_q [ButtonCount];
  logic [ButtonCount-1:0] deb_q, deb_d;
  logic [LevelW-1:0]      level_q, level_d;
  logic                   pend_q, pend_d;
  logic                   loaded_q;

  // Result register
  logic                   out_vld_q;
  logic [OutDataW-1:0]    out_q, out_d;

  logic in_fire;

  // Unpacked input beat
  logic [AxisW-1:0]       joy_x, joy_y;
  logic [5:0]             pins;
  logic                   dim_ready;
  logic [DutyW-1:0]       dim_duty;
  logic [ButtonCount-1:0] raw;
  logic [LevelW-1:0]      lvl_base, start_clamped;
  logic                   step_down, step_up, save;
  logic                   fade;
  logic [DutyW-1:0]       duty;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  assign joy_x     = s_axis_tdata[11:0];
  assign joy_y     = s_axis_tdata[23:12];
  assign pins      = s_axis_tdata[29:24];
  assign dim_ready = s_axis_tdata[30];
  assign dim_duty  = s_axis_tdata[43:31];

  // Decode axes and invert active-low pins
  always_comb begin
    raw          = '0;
    raw[BtnUp]   = joy_y > high_thr_q;
    raw[BtnDown] = !raw[BtnUp] && (joy_y > low_thr_q);
    raw[BtnLeft] = joy_x > high_thr_q;
    raw[BtnRight] = !raw[BtnLeft] && (joy_x > low_thr_q);
    raw[ButtonCount-1:BtnPin0] = ~pins;
  end

  // Debounce: two equal samples set the output, mixed samples hold it
  always_comb begin
    deb_d = deb_q;
    for (int i = 0; i < ButtonCount; i++) begin
      if (!hist_q[i][0] && !raw[i]) begin
        deb_d[i] = 1'b0;
      end else if (hist_q[i][0] && raw[i]) begin
        deb_d[i] = 1'b1;
      end
    end
  end

  // Step the backlight level and decide on a fade request
  always_comb begin
    start_clamped = (start_lvl_q > LevelTop) ? LevelTop : start_lvl_q;
    lvl_base  = loaded_q ? level_q : start_clamped;
    step_down = deb_d[BtnStart] && deb_d[BtnDown] && !deb_q[BtnDown];
    step_up   = deb_d[BtnStart] && !step_down && deb_d[BtnUp] && !deb_q[BtnUp];
    save      = step_down || step_up;
    level_d   = lvl_base;
    if (step_down && lvl_base != '0) begin
      level_d = lvl_base - 1'b1;
    end else if (step_up && lvl_base < LevelTop) begin
      level_d = lvl_base + 1'b1;
    end
    if (level_d > LevelTop) begin
      level_d = LevelTop;
    end
    duty   = duty_tbl_q[level_d[LvlIdxW-1:0]];
    pend_d = pend_q || save;
    fade   = 1'b0;
    if (dim_ready) begin
      fade   = pend_d || (dim_duty != duty);
      pend_d = 1'b0;
    end
    out_d = {5'b0, save, fade, duty, level_d, deb_d};
  end

  // Configuration writes; duty is derived once per percent write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q   <= LowThreshRst;
      high_thr_q  <= HighThreshRst;
      start_lvl_q <= StartLevelRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOW_THRESH:  low_thr_q   <= cfg_data_i;
        CFG_HIGH_THRESH: high_thr_q  <= cfg_data_i;
        CFG_START_LEVEL: start_lvl_q <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < LEVEL_COUNT; g++) begin : g_duty
    localparam logic [CfgIdxW-1:0] MyIdx = CfgIdxW'(CFG_PCT_LEVEL0) + CfgIdxW'(g);
    localparam logic [PctW-1:0] PctRst = (g == 0) ? PctRst0 :
                                         (g == 1) ? PctRst1 :
                                         (g == 2) ? PctRst2 : PctRst3;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        duty_tbl_q[g] <= duty_of_pct(PctRst);
      end else if (cfg_valid_i && cfg_index_i == MyIdx) begin
        duty_tbl_q[g] <= duty_of_pct(cfg_data_i[PctW-1:0]);
      end
    end
  end

  // Advance tick state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ButtonCount; i++) begin
        hist_q[i] <= 2'b11;
      end
      deb_q    <= '0;
      level_q  <= LevelRst;
      pend_q   <= 1'b0;
      loaded_q <= 1'b0;
    end else if (in_fire) begin
      for (int i = 0; i < ButtonCount; i++) begin
        hist_q[i] <= {hist_q[i][0], raw[i]};
      end
      deb_q    <= deb_d;
      level_q  <= level_d;
      pend_q   <= pend_d;
      loaded_q <= 1'b1;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  // A fade request always clears the pending change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && fade |=> !pend_q)
    else $error("pending change survived a fade request");

  // The level never leaves its range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q |-> level_q <= LevelTop)
    else $error("backlight level out of range");

  // Without a step the level only moves on the first tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && loaded_q && !save |=> $stable(level_q))
    else $error("level changed without a step");

  // After any accepted beat the start level has been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> loaded_q)
    else $error("start level not loaded");

endmodule
